// File: rtl/dkrh_pkg.sv
// dkrh_pkg: constants, tables and helpers for the DNA k-mer rolling hash.
// No dependencies; imported by the channel interfaces and dna_kmer_rolling_hash.
package dkrh_pkg;

    localparam int WINDOW_LEN = 27;              // k-mer length, 2..64
    localparam int FILL_W     = $clog2(WINDOW_LEN);

    localparam int CHAR_W = 8;
    localparam int CODE_W = 2;
    localparam int HASH_W = 30;
    localparam int SUM_W  = 36;                  // 31*h + code + removal term < 62*P
    localparam int REM_W  = 33;                  // partial remainder < 6*P

    localparam longint unsigned HASH_MOD  = 64'd1000000007;
    localparam longint unsigned HASH_BASE = 64'd31;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

    localparam logic [CODE_W-1:0] CODE_A     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 2'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 2'd2;
    localparam logic [CODE_W-1:0] CODE_OTHER = 2'd3;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [SUM_W-1:0]  add_tab_t  [4];
    typedef logic [SUM_W-1:0]  mult_tab_t [64];

    function automatic code_t base_code(input char_t ch);
        code_t c;
        case (ch)
            CHAR_A:  c = CODE_A;
            CHAR_C:  c = CODE_C;
            CHAR_G:  c = CODE_G;
            default: c = CODE_OTHER;
        endcase
        return c;
    endfunction

    // 31^(WINDOW_LEN-1) mod P, evaluated at elaboration
    function automatic longint unsigned oldest_weight();
        longint unsigned w;
        w = 64'd1;
        for (int i = 0; i < WINDOW_LEN - 1; i++)
            w = (w * HASH_BASE) % HASH_MOD;
        return w;
    endfunction

    // 31 * ((P - code*W mod P) mod P): removal of the oldest code, already scaled
    function automatic add_tab_t build_add_tab();
        add_tab_t        tab;
        longint unsigned drop;
        for (int c = 0; c < 4; c++) begin
            drop   = (longint'(c) * oldest_weight()) % HASH_MOD;
            tab[c] = SUM_W'(((HASH_MOD - drop) % HASH_MOD) * HASH_BASE);
        end
        return tab;
    endfunction

    function automatic mult_tab_t build_mult_tab();
        mult_tab_t tab;
        for (int j = 0; j < 64; j++)
            tab[j] = SUM_W'(longint'(j) * HASH_MOD);
        return tab;
    endfunction

    localparam add_tab_t  ADD_TAB  = build_add_tab();
    localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

// File: rtl/dkrh_char_if.sv
// dkrh_char_if: valid/ready channel carrying one sequence character.
// Depends on dkrh_pkg.
interface dkrh_char_if
    import dkrh_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// File: rtl/dkrh_hash_if.sv
// dkrh_hash_if: valid/ready channel carrying one 27-mer window hash.
// Depends on dkrh_pkg.
interface dkrh_hash_if
    import dkrh_pkg::*;
;
    logic  valid;
    logic  ready;
    hash_t window_hash;

    modport source (output valid, output window_hash, input ready);
    modport sink   (input valid, input window_hash, output ready);
endinterface

// File: rtl/dna_kmer_rolling_hash.sv
// dna_kmer_rolling_hash: streaming Rabin-Karp hash (base 31 mod 1000000007) over DNA k-mers.
// Depends on dkrh_pkg, dkrh_char_if, dkrh_hash_if.
//
//   channel   dir   payload                  transaction
//   char_ch   in    char_in[7:0]             one sequence character
//   hash_ch   out   window_hash[29:0]        hash of the last WINDOW_LEN bases
//
// One character per cycle while hash_ch is not stalled; the hash of an item is on hash_ch the cycle after it is taken.
// The combinational path is the hash update: 31*h plus code and removal term, then a
// reduction mod P by a table estimate of the quotient and one parallel compare step.
// Reset clears the window, the hash and the fill count; the first WINDOW_LEN-1 items give
// no output. A stalled output holds the hash register and blocks new characters only then.
module dna_kmer_rolling_hash
    import dkrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dkrh_char_if.sink   char_ch,
    dkrh_hash_if.source hash_ch
);

    code_t             window_reg [WINDOW_LEN];
    hash_t             hash_reg;
    hash_t             hash_next;
    logic [FILL_W-1:0] fill_reg;
    logic              out_valid_reg;
    logic              in_fire;
    logic              full;
    code_t             code;
    logic [SUM_W-1:0]  sum;
    logic [5:0]        q_est;
    logic [SUM_W-1:0]  part;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  sub;

    assign char_ch.ready       = !out_valid_reg || hash_ch.ready;
    assign in_fire             = char_ch.valid && char_ch.ready;
    assign full                = (fill_reg == FILL_W'(WINDOW_LEN - 1));
    assign code                = base_code(char_ch.char_in);
    assign hash_ch.valid       = out_valid_reg;
    assign hash_ch.window_hash = hash_reg;

    // P is just below 2^30, so sum>>30 undershoots the quotient by at most five
    always_comb
    begin
        sum   = ({{(SUM_W-HASH_W){1'b0}}, hash_reg} << 5)
              - {{(SUM_W-HASH_W){1'b0}}, hash_reg}
              + {{(SUM_W-CODE_W){1'b0}}, code}
              + ADD_TAB[window_reg[0]];
        q_est = sum[SUM_W-1:HASH_W];
        part  = sum - MULT_TAB[q_est];
        rem   = part[REM_W-1:0];
        sub   = '0;
        for (int j = 1; j <= 5; j++) begin
            if (rem >= MULT_TAB[j][REM_W-1:0])
                sub = MULT_TAB[j][REM_W-1:0];
        end
        hash_next = HASH_W'(rem - sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++)
                window_reg[i] <= CODE_A;
            hash_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                    window_reg[i] <= window_reg[i+1];
                window_reg[WINDOW_LEN-1] <= code;
                hash_reg      <= hash_next;
                out_valid_reg <= full;
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
            end else if (hash_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
